// ===== src/frps_pkg.sv =====
// Shared types and constants of the frame rate period statistics core.
package frps_pkg;

  // Fixed field widths
  localparam int unsigned PERIOD_W     = 32;
  localparam int unsigned COUNT_W      = 17;
  localparam int unsigned AVG_FRAMES_W = 16;
  localparam int unsigned SPAN_MAX_W   = 64;
  localparam int unsigned US_W         = 20;
  localparam int unsigned CFG_INDEX_W  = 2;
  localparam int unsigned CFG_DATA_W   = 16;

  // Constants of the statistics
  localparam logic [US_W-1:0]         US_PER_S          = 20'd1000000;
  localparam logic [PERIOD_W-1:0]     ALL32             = 32'hFFFF_FFFF;
  localparam logic [PERIOD_W-1:0]     MIN_RESET         = 32'h4000_0000;
  localparam logic [COUNT_W-1:0]      COUNT_MAX         = 17'h1FFFF;
  localparam logic [AVG_FRAMES_W-1:0] AVG_FRAMES_RESET  = 16'd100;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_AVG_FRAMES  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_DELAY_START = 2'd1;

  // Job queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = 1;
  localparam int unsigned QUEUE_CNT_W = 2;

  // One classified frame, handed from front to back
  typedef struct packed {
    logic [SPAN_MAX_W-1:0] span;
    logic [COUNT_W-1:0]    count;
    logic [PERIOD_W-1:0]   period;
    logic [PERIOD_W-1:0]   min_period;
    logic [PERIOD_W-1:0]   max_period;
    logic                  fresh;
    logic                  active;
  } frps_job_t;

  // Back end sequencer
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_PREP,
    BK_DIV,
    BK_DONE
  } bk_state_t;

endpackage

// ===== src/frps_front.sv =====
// Front end: accepts frame events, tracks period statistics and issues jobs.
module frps_front #(
  parameter int unsigned TIME_BITS = 40
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic [TIME_BITS-1:0]                 in_timestamp_us,
  output logic                                 in_stall,
  input  logic                                 cfg_valid,
  input  logic [frps_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [frps_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 q_full,
  output logic                                 q_push,
  output frps_pkg::frps_job_t                  q_job
);

  localparam int unsigned WIDE_W = (TIME_BITS > 32) ? TIME_BITS : 32;

  logic [TIME_BITS-1:0]                  prev_r, prev_nxt;
  logic [TIME_BITS-1:0]                  start_r, start_nxt;
  logic [frps_pkg::COUNT_W-1:0]          count_r, count_nxt;
  logic                                  started_r, started_nxt;
  logic [frps_pkg::PERIOD_W-1:0]         min_r, min_nxt;
  logic [frps_pkg::PERIOD_W-1:0]         max_r, max_nxt;
  logic [frps_pkg::AVG_FRAMES_W-1:0]     af_r, af_nxt;

  logic [TIME_BITS-1:0]                  diff;
  logic [WIDE_W-1:0]                     diff_wide;
  logic [TIME_BITS-1:0]                  span;
  logic [frps_pkg::PERIOD_W-1:0]         period;
  logic [frps_pkg::COUNT_W-1:0]          af_wide;
  logic [frps_pkg::COUNT_W-1:0]          count_inc;
  logic                                  accept;
  logic                                  fresh;

  // Period since previous frame, saturated to 32 bits
  always_comb begin
    diff      = in_timestamp_us - prev_r;
    diff_wide = WIDE_W'(diff);
    period    = (diff_wide > WIDE_W'(frps_pkg::ALL32)) ? frps_pkg::ALL32
                                                       : diff_wide[frps_pkg::PERIOD_W-1:0];
    span      = in_timestamp_us - start_r;
    af_wide   = frps_pkg::COUNT_W'(af_r);
    count_inc = (count_r < frps_pkg::COUNT_MAX) ? count_r + 1'b1 : count_r;
  end

  // Hold the input while the queue is full or a register write is taken
  assign in_stall = q_full | cfg_valid;
  assign accept   = in_valid & ~in_stall;

  // Update statistics on a configuration write or an accepted frame
  always_comb begin
    prev_nxt    = prev_r;
    start_nxt   = start_r;
    count_nxt   = count_r;
    started_nxt = started_r;
    min_nxt     = min_r;
    max_nxt     = max_r;
    af_nxt      = af_r;
    fresh       = 1'b0;
    if (cfg_valid) begin
      unique case (cfg_index)
        frps_pkg::CFG_AVG_FRAMES: begin
          af_nxt = cfg_data;
        end
        frps_pkg::CFG_DELAY_START: begin
          started_nxt = ~cfg_data[0];
          count_nxt   = '0;
          start_nxt   = prev_r;
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      prev_nxt = in_timestamp_us;
      if (!started_r) begin
        if (count_r > af_wide) begin
          started_nxt = 1'b1;
        end
        count_nxt = count_inc;
      end else begin
        if (period < min_r) begin
          min_nxt = period;
        end else if (period > max_r) begin
          max_nxt = period;
        end
        if (count_r >= af_wide) begin
          fresh     = 1'b1;
          start_nxt = in_timestamp_us;
          count_nxt = '0;
        end else begin
          count_nxt = count_inc;
        end
      end
    end
  end

  // Build the job for the back end
  always_comb begin
    q_push           = accept & ~cfg_valid;
    q_job.span       = frps_pkg::SPAN_MAX_W'(span);
    q_job.count      = count_r;
    q_job.period     = period;
    q_job.min_period = min_nxt;
    q_job.max_period = max_nxt;
    q_job.fresh      = fresh;
    q_job.active     = started_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r    <= '0;
      start_r   <= '0;
      count_r   <= '0;
      started_r <= 1'b1;
      min_r     <= frps_pkg::MIN_RESET;
      max_r     <= '0;
      af_r      <= frps_pkg::AVG_FRAMES_RESET;
    end else begin
      prev_r    <= prev_nxt;
      start_r   <= start_nxt;
      count_r   <= count_nxt;
      started_r <= started_nxt;
      min_r     <= min_nxt;
      max_r     <= max_nxt;
      af_r      <= af_nxt;
    end
  end

`ifndef SYNTHESIS
  a_fresh_only_active: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && q_job.fresh) |-> q_job.active)
    else $error("fresh average issued while statistics inactive");
`endif

endmodule

// ===== src/frps_queue.sv =====
// Short job queue that decouples the front end from the divider back end.
module frps_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  frps_pkg::frps_job_t push_job,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output frps_pkg::frps_job_t head_job
);

  frps_pkg::frps_job_t                 mem_r [frps_pkg::QUEUE_DEPTH];
  logic [frps_pkg::QUEUE_PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [frps_pkg::QUEUE_PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [frps_pkg::QUEUE_CNT_W-1:0]    cnt_r, cnt_nxt;

  // Advance pointers and fill count
  always_comb begin
    full       = (cnt_r == frps_pkg::QUEUE_CNT_W'(frps_pkg::QUEUE_DEPTH));
    head_valid = (cnt_r != '0);
    head_job   = mem_r[rd_ptr_r];
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !(push && !pop))
    else $error("job queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("job queue underflow");
`endif

endmodule

// ===== src/frps_back.sv =====
// Back end: computes the average frequency with a bit-serial divider and drives results.
module frps_back #(
  parameter int unsigned TIME_BITS = 40,
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             head_valid,
  input  frps_pkg::frps_job_t              head_job,
  output logic                             pop,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [frps_pkg::PERIOD_W-1:0]    out_period_us,
  output logic [frps_pkg::PERIOD_W-1:0]    out_min_period_us,
  output logic [frps_pkg::PERIOD_W-1:0]    out_max_period_us,
  output logic [frps_pkg::PERIOD_W-1:0]    out_average_hz,
  output logic                             out_average_fresh,
  output logic                             out_stats_active
);

  localparam int unsigned PROD_W = frps_pkg::COUNT_W + frps_pkg::US_W;
  localparam int unsigned NUM_W  = PROD_W + FRAC_BITS;
  localparam int unsigned DVD_W  = ((NUM_W > TIME_BITS) ? NUM_W : TIME_BITS) + 1;
  localparam int unsigned Q_W    = frps_pkg::PERIOD_W;
  localparam int unsigned STEP_W = $clog2(Q_W);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(Q_W - 1);

  frps_pkg::bk_state_t              st_r, st_nxt;
  frps_pkg::frps_job_t              job_r, job_nxt;
  logic [PROD_W-1:0]                prod_r, prod_nxt;
  logic [TIME_BITS-1:0]             rem_r, rem_nxt;
  logic [Q_W-1:0]                   low_r, low_nxt;
  logic [Q_W-1:0]                   quo_r, quo_nxt;
  logic [STEP_W-1:0]                step_r, step_nxt;
  logic [frps_pkg::PERIOD_W-1:0]    avg_r, avg_nxt;

  logic                             out_valid_r, out_valid_nxt;
  logic [frps_pkg::PERIOD_W-1:0]    out_period_r, out_period_nxt;
  logic [frps_pkg::PERIOD_W-1:0]    out_min_r, out_min_nxt;
  logic [frps_pkg::PERIOD_W-1:0]    out_max_r, out_max_nxt;
  logic [frps_pkg::PERIOD_W-1:0]    out_avg_r, out_avg_nxt;
  logic                             out_fresh_r, out_fresh_nxt;
  logic                             out_active_r, out_active_nxt;

  logic [TIME_BITS-1:0]             span;
  logic [DVD_W-1:0]                 dvd;
  logic [DVD_W-1:0]                 dvd_hi;
  logic                             sat;
  logic [TIME_BITS:0]               trial;
  logic [TIME_BITS:0]               trial_sub;
  logic                             qbit;
  logic                             slot_free;
  logic                             load;
  frps_pkg::frps_job_t              load_job;
  logic [frps_pkg::PERIOD_W-1:0]    load_avg;

  // Dividend with rounding term, overflow check and one restoring step
  always_comb begin
    span      = job_r.span[TIME_BITS-1:0];
    dvd       = (DVD_W'(prod_r) << FRAC_BITS) + DVD_W'(span >> 1);
    dvd_hi    = dvd >> Q_W;
    sat       = (dvd_hi >= DVD_W'(span));
    trial     = {rem_r, low_r[Q_W-1]};
    trial_sub = trial - {1'b0, span};
    qbit      = (trial >= {1'b0, span});
  end

  assign slot_free = ~out_valid_r | ~out_stall;

  // Sequencer: pass plain frames straight through, divide for fresh averages
  always_comb begin
    st_nxt   = st_r;
    job_nxt  = job_r;
    prod_nxt = prod_r;
    rem_nxt  = rem_r;
    low_nxt  = low_r;
    quo_nxt  = quo_r;
    step_nxt = step_r;
    avg_nxt  = avg_r;
    pop      = 1'b0;
    load     = 1'b0;
    load_job = head_job;
    load_avg = avg_r;
    unique case (st_r)
      frps_pkg::BK_IDLE: begin
        if (head_valid && slot_free) begin
          pop = 1'b1;
          if (head_job.fresh) begin
            job_nxt = head_job;
            st_nxt  = frps_pkg::BK_MUL;
          end else begin
            load = 1'b1;
          end
        end
      end
      frps_pkg::BK_MUL: begin
        prod_nxt = PROD_W'(job_r.count * frps_pkg::US_PER_S);
        st_nxt   = frps_pkg::BK_PREP;
      end
      frps_pkg::BK_PREP: begin
        if (sat) begin
          avg_nxt = frps_pkg::ALL32;
          st_nxt  = frps_pkg::BK_DONE;
        end else begin
          rem_nxt  = dvd_hi[TIME_BITS-1:0];
          low_nxt  = dvd[Q_W-1:0];
          quo_nxt  = '0;
          step_nxt = '0;
          st_nxt   = frps_pkg::BK_DIV;
        end
      end
      frps_pkg::BK_DIV: begin
        rem_nxt  = qbit ? trial_sub[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
        low_nxt  = low_r << 1;
        quo_nxt  = {quo_r[Q_W-2:0], qbit};
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_LAST) begin
          avg_nxt = {quo_r[Q_W-2:0], qbit};
          st_nxt  = frps_pkg::BK_DONE;
        end
      end
      frps_pkg::BK_DONE: begin
        if (slot_free) begin
          load     = 1'b1;
          load_job = job_r;
          st_nxt   = frps_pkg::BK_IDLE;
        end
      end
      default: begin
        st_nxt = frps_pkg::BK_IDLE;
      end
    endcase
  end

  // Output register: load a result, drop it once taken, hold while stalled
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_period_nxt = out_period_r;
    out_min_nxt    = out_min_r;
    out_max_nxt    = out_max_r;
    out_avg_nxt    = out_avg_r;
    out_fresh_nxt  = out_fresh_r;
    out_active_nxt = out_active_r;
    if (load) begin
      out_valid_nxt  = 1'b1;
      out_period_nxt = load_job.period;
      out_min_nxt    = load_job.min_period;
      out_max_nxt    = load_job.max_period;
      out_avg_nxt    = load_avg;
      out_fresh_nxt  = load_job.fresh;
      out_active_nxt = load_job.active;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    job_r        <= job_nxt;
    prod_r       <= prod_nxt;
    rem_r        <= rem_nxt;
    low_r        <= low_nxt;
    quo_r        <= quo_nxt;
    step_r       <= step_nxt;
    out_period_r <= out_period_nxt;
    out_min_r    <= out_min_nxt;
    out_max_r    <= out_max_nxt;
    out_avg_r    <= out_avg_nxt;
    out_fresh_r  <= out_fresh_nxt;
    out_active_r <= out_active_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= frps_pkg::BK_IDLE;
      avg_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      avg_r       <= avg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_period_us     = out_period_r;
  assign out_min_period_us = out_min_r;
  assign out_max_period_us = out_max_r;
  assign out_average_hz    = out_avg_r;
  assign out_average_fresh = out_fresh_r;
  assign out_stats_active  = out_active_r;

`ifndef SYNTHESIS
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == frps_pkg::BK_DIV) |-> (rem_r < span))
    else $error("divider remainder not below divisor");
  a_div_ends_in_done: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == frps_pkg::BK_DIV && step_r == STEP_LAST) |=> (st_r == frps_pkg::BK_DONE))
    else $error("divider did not finish after last step");
  a_done_is_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == frps_pkg::BK_DONE) |-> job_r.fresh)
    else $error("divider ran for a frame without a new average");
`endif

endmodule

// ===== src/frame_rate_period_statistics_core.sv =====
// Top level of the frame rate period statistics core.
//
// Input channel: one transaction per frame event, carrying in_timestamp_us,
// a free-running microsecond time that wraps modulo 2^TIME_BITS.
// Output channel: one transaction per frame with the period since the last
// frame, the minimum and maximum period, the latest average frequency
// (unsigned fixed point, FRAC_BITS fraction bits), a flag for a new average
// and the statistics-active flag.
// Configuration: cfg_index 0 sets the averaging frame count, index 1 sets
// delayed start; other indexes are ignored. cfg_ready is always high.
// Frames without a new average go from the queue head to the output register;
// one that closes an averaging window passes multiply, setup and the 32 steps
// of the one-bit-per-cycle divider (setup skips the divider when saturated).
// A two-entry job queue sits between the statistics front end and the
// divider, so frames are accepted while a division runs until it fills.
// Reset: synchronous on rst_n low; statistics run at once, minimum 2^30,
// maximum and average 0, time base 0. No clearing pass is needed.
// A stalled output holds its transaction; in_stall rises once the queue fills
// and while a configuration write is taken.
module frame_rate_period_statistics_core #(
  parameter int unsigned TIME_BITS = 40,
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic [TIME_BITS-1:0]             in_timestamp_us,
  output logic                             in_stall,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [frps_pkg::PERIOD_W-1:0]    out_period_us,
  output logic [frps_pkg::PERIOD_W-1:0]    out_min_period_us,
  output logic [frps_pkg::PERIOD_W-1:0]    out_max_period_us,
  output logic [frps_pkg::PERIOD_W-1:0]    out_average_hz,
  output logic                             out_average_fresh,
  output logic                             out_stats_active,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [frps_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [frps_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic                q_full;
  logic                q_push;
  frps_pkg::frps_job_t q_job;
  logic                q_pop;
  logic                q_head_valid;
  frps_pkg::frps_job_t q_head_job;

  assign cfg_ready = 1'b1;

  frps_front #(
    .TIME_BITS (TIME_BITS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_timestamp_us (in_timestamp_us),
    .in_stall        (in_stall),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_job           (q_job)
  );

  frps_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (q_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_job   (q_head_job)
  );

  frps_back #(
    .TIME_BITS (TIME_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head_valid        (q_head_valid),
    .head_job          (q_head_job),
    .pop               (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_period_us     (out_period_us),
    .out_min_period_us (out_min_period_us),
    .out_max_period_us (out_max_period_us),
    .out_average_hz    (out_average_hz),
    .out_average_fresh (out_average_fresh),
    .out_stats_active  (out_stats_active)
  );

endmodule

// ===== sim/tb_frame_rate_period_statistics_core.sv =====
// Self-checking testbench of the frame rate period statistics core.
`timescale 1ns / 100ps

module tb_frame_rate_period_statistics_core;

  localparam int unsigned TIME_W      = 40;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned TAIL_CYCLES = 64;

  // Indexes that the block must ignore
  localparam logic [frps_pkg::CFG_INDEX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [frps_pkg::CFG_INDEX_W-1:0] CFG_SPARE_HI = 2'd3;

  typedef struct packed {
    logic [frps_pkg::PERIOD_W-1:0] period;
    logic [frps_pkg::PERIOD_W-1:0] shortest;
    logic [frps_pkg::PERIOD_W-1:0] longest;
    logic [frps_pkg::PERIOD_W-1:0] rate;
    logic                          fresh;
    logic                          active;
  } frame_report_t;

  typedef struct packed {
    logic [frps_pkg::CFG_INDEX_W-1:0] index;
    logic [frps_pkg::CFG_DATA_W-1:0]  data;
  } reg_write_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_valid = 1'b0;
  logic [TIME_W-1:0]                in_timestamp_us = '0;
  logic                             in_stall;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic [frps_pkg::PERIOD_W-1:0]    out_period_us;
  logic [frps_pkg::PERIOD_W-1:0]    out_min_period_us;
  logic [frps_pkg::PERIOD_W-1:0]    out_max_period_us;
  logic [frps_pkg::PERIOD_W-1:0]    out_average_hz;
  logic                             out_average_fresh;
  logic                             out_stats_active;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [frps_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [frps_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  // Frame statistics tracked by the testbench
  logic [frps_pkg::AVG_FRAMES_W-1:0] window_frames;
  logic [TIME_W-1:0]                 last_frame_time;
  logic [TIME_W-1:0]                 window_start_time;
  logic [frps_pkg::COUNT_W-1:0]      window_count;
  bit                                stats_on;
  logic [frps_pkg::PERIOD_W-1:0]     shortest_period;
  logic [frps_pkg::PERIOD_W-1:0]     longest_period;
  logic [frps_pkg::PERIOD_W-1:0]     mean_rate;

  frame_report_t frame_reports[$];
  reg_write_t    reg_writes[$];

  int          send_idle_pct;
  int          recv_stall_pct;
  int          error_count = 0;
  int unsigned cycle_count = 0;

  frame_rate_period_statistics_core #(
    .TIME_BITS(TIME_W),
    .FRAC_BITS(8)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_timestamp_us   (in_timestamp_us),
    .in_stall          (in_stall),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_period_us     (out_period_us),
    .out_min_period_us (out_min_period_us),
    .out_max_period_us (out_max_period_us),
    .out_average_hz    (out_average_hz),
    .out_average_fresh (out_average_fresh),
    .out_stats_active  (out_stats_active),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #6 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_frame_rate_period_statistics_core NOT OK");
      $finish;
    end
  end

  // Rounded average frequency in 24.8 Hz, saturated
  function automatic logic [frps_pkg::PERIOD_W-1:0] average_rate(
      input logic [frps_pkg::COUNT_W-1:0] count,
      input logic [TIME_W-1:0] span);
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] quot;
    if (span == '0) return frps_pkg::ALL32;
    den = 64'(span);
    num = (64'(count) * 64'(frps_pkg::US_PER_S)) << 8;
    quot = (num + den / 2) / den;
    return (quot > 64'(frps_pkg::ALL32)) ? frps_pkg::ALL32 : quot[frps_pkg::PERIOD_W-1:0];
  endfunction

  task automatic clear_frame_stats();
    window_frames     = frps_pkg::AVG_FRAMES_RESET;
    last_frame_time   = '0;
    window_start_time = '0;
    window_count      = '0;
    stats_on          = 1'b1;
    shortest_period   = frps_pkg::MIN_RESET;
    longest_period    = '0;
    mean_rate         = '0;
  endtask

  // Advance the statistics by one frame and queue the report it produces
  task automatic account_frame(input logic [TIME_W-1:0] stamp);
    logic [TIME_W-1:0] delta;
    frame_report_t     rep;
    delta = stamp - last_frame_time;
    rep.period = (delta > TIME_W'(frps_pkg::ALL32)) ? frps_pkg::ALL32
                                                    : delta[frps_pkg::PERIOD_W-1:0];
    rep.fresh = 1'b0;
    last_frame_time = stamp;
    if (!stats_on) begin
      if (window_count > frps_pkg::COUNT_W'(window_frames)) stats_on = 1'b1;
      if (window_count < frps_pkg::COUNT_MAX) window_count = window_count + 1'b1;
    end else begin
      if (rep.period < shortest_period) shortest_period = rep.period;
      else if (rep.period > longest_period) longest_period = rep.period;
      if (window_count >= frps_pkg::COUNT_W'(window_frames)) begin
        mean_rate = average_rate(window_count, stamp - window_start_time);
        rep.fresh = 1'b1;
        window_start_time = stamp;
        window_count = '0;
      end else if (window_count < frps_pkg::COUNT_MAX) begin
        window_count = window_count + 1'b1;
      end
    end
    rep.shortest = shortest_period;
    rep.longest  = longest_period;
    rep.rate     = mean_rate;
    rep.active   = stats_on;
    frame_reports.push_back(rep);
  endtask

  task automatic apply_reg_write(input reg_write_t w);
    if (w.index == frps_pkg::CFG_AVG_FRAMES) begin
      window_frames = w.data;
    end else if (w.index == frps_pkg::CFG_DELAY_START) begin
      stats_on          = !w.data[0];
      window_count      = '0;
      window_start_time = last_frame_time;
    end
  endtask

  // Send one frame transaction after a random idle gap
  task automatic send_frame(input logic [TIME_W-1:0] stamp);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_timestamp_us <= stamp;
    do @(posedge clk); while (in_stall);
    account_frame(stamp);
  endtask

  // Drop valid and wait until every queued report has come back
  task automatic settle_frames();
    if (in_valid) in_valid <= 1'b0;
    while (frame_reports.size() > 0) @(posedge clk);
  endtask

  // Issue the queued register writes back to back
  task automatic commit_reg_writes();
    reg_write_t w;
    settle_frames();
    while (reg_writes.size() > 0) begin
      w = reg_writes.pop_front();
      cfg_valid <= 1'b1;
      cfg_index <= w.index;
      cfg_data  <= w.data;
      do @(posedge clk); while (!cfg_ready);
      apply_reg_write(w);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [frps_pkg::PERIOD_W-1:0] want,
                             input logic [frps_pkg::PERIOD_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  // Check each result transaction and drive the receiver stall
  always @(posedge clk) begin
    frame_report_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (frame_reports.size() == 0) begin
        $error("result transaction with nothing pending, period_us %0d", out_period_us);
        error_count++;
      end else begin
        want = frame_reports.pop_front();
        check_field("period_us", want.period, out_period_us);
        check_field("min_period_us", want.shortest, out_min_period_us);
        check_field("max_period_us", want.longest, out_max_period_us);
        check_field("average_hz", want.rate, out_average_hz);
        check_field("average_fresh", 32'(want.fresh), 32'(out_average_fresh));
        check_field("stats_active", 32'(want.active), 32'(out_stats_active));
      end
    end
    out_stall <= rst_n && ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Walk min, max, wrap and saturation of the period from the reset state
  task automatic test_field_extremes();
    send_frame(40'd20000);
    send_frame(40'd50000);
    send_frame(40'd60000);
    send_frame(40'hFF_FFFF_FFFF);
    send_frame(40'h00_0000_0000);
    send_frame(40'h55_5555_5555);
    send_frame(40'hAA_AAAA_AAAA);
    send_frame(40'hAA_AAAA_AAAA + 40'h00_FFFF_FFFF);
  endtask

  // Average on every frame: zero span saturates, zero count gives zero
  task automatic test_zero_window();
    reg_writes.push_back('{CFG_SPARE_LO, 16'hFFFF});
    reg_writes.push_back('{frps_pkg::CFG_AVG_FRAMES, 16'h0000});
    reg_writes.push_back('{frps_pkg::CFG_DELAY_START, 16'h0000});
    reg_writes.push_back('{CFG_SPARE_HI, 16'h5A5A});
    commit_reg_writes();
    send_frame(last_frame_time);
    send_frame(last_frame_time + 40'd777);
  endtask

  // Quotient of exactly one half rounds up
  task automatic test_rounding_tie();
    logic [TIME_W-1:0] origin;
    reg_writes.push_back('{frps_pkg::CFG_AVG_FRAMES, 16'd1});
    reg_writes.push_back('{frps_pkg::CFG_DELAY_START, 16'h0000});
    commit_reg_writes();
    origin = last_frame_time;
    send_frame(origin + 40'd100);
    send_frame(origin + 40'd32768);
  endtask

  // Warm-up, then a mid-window change of the frame count, then leave warm-up off
  task automatic test_delayed_start();
    reg_writes.push_back('{frps_pkg::CFG_AVG_FRAMES, 16'd2});
    reg_writes.push_back('{frps_pkg::CFG_DELAY_START, 16'h0001});
    commit_reg_writes();
    repeat (6) send_frame(last_frame_time + 40'd1000);
    reg_writes.push_back('{frps_pkg::CFG_AVG_FRAMES, 16'd1});
    commit_reg_writes();
    repeat (2) send_frame(last_frame_time + 40'd1500);
    reg_writes.push_back('{frps_pkg::CFG_DELAY_START, 16'h8000});
    commit_reg_writes();
  endtask

  // Random windows and frame patterns under the given idle rates
  task automatic test_random_traffic(input int send_pct, input int recv_pct, input int frames);
    int                              sent;
    int                              seg_len;
    int                              pattern;
    int                              pick;
    logic [TIME_W-1:0]               cursor;
    logic [TIME_W-1:0]               base;
    logic [TIME_W-1:0]               step;
    logic [31:0]                     r_hi;
    logic [31:0]                     r_lo;
    logic [frps_pkg::CFG_DATA_W-1:0] word;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    sent = 0;
    while (sent < frames) begin
      // pick the window length, mostly short
      pick = $urandom_range(0, 19);
      if (pick < 10) word = frps_pkg::CFG_DATA_W'($urandom_range(0, 6));
      else if (pick < 15) word = frps_pkg::CFG_DATA_W'($urandom_range(7, 40));
      else if (pick < 17) word = frps_pkg::AVG_FRAMES_RESET;
      else if (pick < 18) word = 16'hFFFF;
      else word = frps_pkg::CFG_DATA_W'($urandom());
      reg_writes.push_back('{frps_pkg::CFG_AVG_FRAMES, word});
      if ($urandom_range(0, 3) != 0) begin
        word = frps_pkg::CFG_DATA_W'($urandom());
        word[0] = ($urandom_range(0, 3) == 0);
        reg_writes.push_back('{frps_pkg::CFG_DELAY_START, word});
      end
      if ($urandom_range(0, 5) == 0)
        reg_writes.push_back('{($urandom_range(0, 1) != 0) ? CFG_SPARE_HI : CFG_SPARE_LO,
                               frps_pkg::CFG_DATA_W'($urandom())});
      commit_reg_writes();

      seg_len = $urandom_range(8, 40);
      pattern = $urandom_range(0, 9);
      base    = TIME_W'($urandom_range(500, 40000));
      cursor  = last_frame_time;
      if (pattern == 9) cursor = 40'hFF_FFFF_FFFF - TIME_W'($urandom_range(0, 50000));
      repeat (seg_len) begin
        r_hi = $urandom();
        r_lo = $urandom();
        case (pattern)
          5: begin
            step = TIME_W'($urandom_range(0, 2));
          end
          6: begin
            step = {r_hi[7:0], r_lo};
          end
          7: begin
            cursor = {r_hi[7:0], r_lo};
            step = '0;
          end
          8: begin
            step = ($urandom_range(0, 4) == 0) ? '0 : base + TIME_W'(r_lo[5:0]);
          end
          default: begin
            step = base + TIME_W'(r_lo[5:0]);
          end
        endcase
        cursor = cursor + step;
        send_frame(cursor);
        sent++;
      end
    end
  endtask

  initial begin
    send_idle_pct  = 32;
    recv_stall_pct = 46;
    clear_frame_stats();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_field_extremes();
    test_zero_window();
    test_rounding_tie();
    test_delayed_start();

    test_random_traffic(32, 46, 320);
    test_random_traffic(46, 32, 320);
    test_random_traffic(0, 0, 310);

    // Drain and let the pipeline go quiet
    settle_frames();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && frame_reports.size() == 0) begin
      $display("tb_frame_rate_period_statistics_core OK");
    end else begin
      $display("tb_frame_rate_period_statistics_core NOT OK");
    end
    $finish;
  end

endmodule
